>>> sv/mst_pkg.sv
// Shared types, constants and controller commands for the multiset table.
package mst_pkg;

  localparam int unsigned MaxItemsDefault    = 256;
  localparam int unsigned MaxDistinctDefault = 256;
  localparam int unsigned ValueBitsDefault   = 32;

  localparam int unsigned KindW  = 2;
  localparam int unsigned InValW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = 9;

  localparam logic [KindW-1:0] KindAdd    = 2'd0;
  localparam logic [KindW-1:0] KindRemove = 2'd1;

  localparam logic [StatW-1:0] StatDone    = 2'd0;
  localparam logic [StatW-1:0] StatMissing = 2'd1;
  localparam logic [StatW-1:0] StatFull    = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StFind,
    StCount,
    StDecide,
    StLast,
    StShift,
    StRecount,
    StDshift,
    StRenum,
    StFinal,
    StFcount,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word
    logic clr_ptr;   // restart the scan pointer
    logic step;      // advance the scan pointer
    logic find;      // distinct search step
    logic count;     // occurrence counting step
    logic add;       // perform the append
    logic last;      // backward search step
    logic shift;     // occurrence shift step
    logic dshift;    // distinct shift step
    logic renum;     // renumber step
    logic drop;      // decrement occurrence fill
    logic ddrop;     // decrement distinct fill
    logic clr_cnt;   // clear occurrence count
    logic set_stat;  // latch status
    logic [1:0] stat;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic is_remove;
    logic found;
    logic scan_done;  // pointer reached the end of the active range
    logic rd_hit;     // registered read matched
    logic occ_full;
    logic dist_full;
    logic cnt_zero;
  } stat_t;

endpackage

>>> sv/mst_if.sv
// Valid/ready channel interfaces for input and result words.
interface mst_in_if;
  import mst_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic signed [InValW-1:0] value;
  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mst_out_if;
  import mst_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [CntW-1:0]  occurrences;
  logic [CntW-1:0]  total_items;
  logic [CntW-1:0]  distinct_items;
  modport source (output valid, output status, output occurrences, output total_items,
                  output distinct_items, input ready);
  modport sink   (input valid, input status, input occurrences, input total_items,
                  input distinct_items, output ready);
endinterface

>>> sv/mst_datapath.sv
// Datapath of the multiset table: both stores, fill counts, pointer and count.
module mst_datapath import mst_pkg::*; #(
  parameter int unsigned MaxItems    = MaxItemsDefault,
  parameter int unsigned MaxDistinct = MaxDistinctDefault,
  parameter int unsigned ValueBits   = ValueBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [KindW-1:0]       kind_i,
  input  logic [InValW-1:0]      value_i,
  output stat_t                  stat_o,
  output logic [StatW-1:0]       status_o,
  output logic [CntW-1:0]        occurrences_o,
  output logic [CntW-1:0]        total_items_o,
  output logic [CntW-1:0]        distinct_items_o
);

  localparam int unsigned IW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned DW = (MaxDistinct > 1) ? $clog2(MaxDistinct) : 1;
  localparam int unsigned IFW = $clog2(MaxItems + 1);
  localparam int unsigned DFW = $clog2(MaxDistinct + 1);
  localparam int unsigned PW = (IFW > DFW) ? IFW : DFW;

  logic [ValueBits-1:0] dmem [MaxDistinct];
  logic [DW-1:0]        omem [MaxItems];

  logic [KindW-1:0]     kind_q;
  logic [ValueBits-1:0] val_q;
  logic [IFW-1:0]       ofill_q;
  logic [DFW-1:0]       dfill_q;
  logic [PW-1:0]        ptr_q;
  logic [DW-1:0]        idx_q;
  logic                 found_q;
  logic [IFW-1:0]       cnt_q;
  logic [IW-1:0]        slot_q;
  logic [StatW-1:0]     stat_q;

  // Registered reads, one per store.
  logic [ValueBits-1:0] drd_q;
  logic [DW-1:0]        ord_q;
  logic                 rvalid_q;
  logic [PW-1:0]        rptr_q;

  logic [PW-1:0] scan_end;
  logic [PW-1:0] rd_ptr;
  logic          rd_hit;

  // Scan end follows the active operation.
  always_comb begin
    if (cmd_i.find || cmd_i.dshift) begin
      scan_end = PW'(dfill_q);
    end else begin
      scan_end = PW'(ofill_q);
    end
  end

  // Read address: the backward search walks down from the top.
  assign rd_ptr = cmd_i.last ? (PW'(ofill_q) - ptr_q - PW'(1)) : ptr_q;

  always_comb begin
    if (cmd_i.find) begin
      rd_hit = (drd_q == val_q);
    end else begin
      rd_hit = (ord_q == idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    drd_q <= dmem[rd_ptr[DW-1:0]];
    ord_q <= omem[rd_ptr[IW-1:0]];
    if (cmd_i.add) begin
      if (!found_q) begin
        dmem[dfill_q[DW-1:0]] <= val_q;
      end
      omem[ofill_q[IW-1:0]] <= found_q ? idx_q : dfill_q[DW-1:0];
    end
    // Shifts write the registered read word one place down.
    if (cmd_i.shift && rvalid_q && rptr_q > PW'(slot_q)) begin
      omem[rptr_q[IW-1:0] - IW'(1)] <= ord_q;
    end
    if (cmd_i.dshift && rvalid_q && rptr_q > PW'(idx_q)) begin
      dmem[rptr_q[DW-1:0] - DW'(1)] <= drd_q;
    end
    if (cmd_i.renum && rvalid_q && ord_q > idx_q) begin
      omem[rptr_q[IW-1:0]] <= ord_q - DW'(1);
    end
    if (cmd_i.load) begin
      kind_q <= kind_i;
      val_q  <= ValueBits'(value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofill_q  <= '0;
      dfill_q  <= '0;
      ptr_q    <= '0;
      rptr_q   <= '0;
      rvalid_q <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      cnt_q    <= '0;
      slot_q   <= '0;
      stat_q   <= StatDone;
    end else begin
      rvalid_q <= cmd_i.step && (ptr_q < scan_end);
      rptr_q   <= rd_ptr;
      if (cmd_i.clr_ptr) begin
        ptr_q    <= '0;
        rvalid_q <= 1'b0;
      end else if (cmd_i.step && ptr_q < scan_end) begin
        ptr_q <= ptr_q + PW'(1);
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end
      if (cmd_i.find && rvalid_q && rd_hit && !found_q) begin
        found_q <= 1'b1;
        idx_q   <= rptr_q[DW-1:0];
      end
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.count && rvalid_q && found_q && rd_hit) begin
        cnt_q <= cnt_q + IFW'(1);
      end
      if (cmd_i.last && rvalid_q && rd_hit) begin
        slot_q <= rptr_q[IW-1:0];
      end
      if (cmd_i.add) begin
        if (!found_q) begin
          idx_q   <= dfill_q[DW-1:0];
          found_q <= 1'b1;
          dfill_q <= dfill_q + DFW'(1);
        end
        ofill_q <= ofill_q + IFW'(1);
      end
      if (cmd_i.drop) begin
        ofill_q <= ofill_q - IFW'(1);
      end
      if (cmd_i.ddrop) begin
        dfill_q <= dfill_q - DFW'(1);
        found_q <= 1'b0;
      end
      if (cmd_i.set_stat) begin
        stat_q <= cmd_i.stat;
      end
    end
  end

  assign stat_o.is_add    = (kind_q == KindAdd);
  assign stat_o.is_remove = (kind_q == KindRemove);
  assign stat_o.found     = found_q;
  assign stat_o.scan_done = (ptr_q >= scan_end) && !rvalid_q;
  assign stat_o.rd_hit    = rvalid_q && rd_hit;
  assign stat_o.occ_full  = (ofill_q >= IFW'(MaxItems));
  assign stat_o.dist_full = (dfill_q >= DFW'(MaxDistinct));
  assign stat_o.cnt_zero  = (cnt_q == '0);

  assign status_o         = stat_q;
  assign occurrences_o    = CntW'(cnt_q);
  assign total_items_o    = CntW'(ofill_q);
  assign distinct_items_o = CntW'(dfill_q);

  // The fill counts never pass their capacities.
  a_ofill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ofill_q <= IFW'(MaxItems)) else $error("occurrence fill overflow");
  a_dfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dfill_q <= DFW'(MaxDistinct)) else $error("distinct fill overflow");
  // No more distinct values than occurrences, apart from a value whose last
  // occurrence is gone while its distinct entry is still being compacted.
  a_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(dfill_q) <= PW'(ofill_q) + PW'(1)) else $error("distinct exceeds occurrences");

endmodule

>>> sv/mst_ctrl.sv
// Controller state machine sequencing the scans of the multiset table.
module mst_ctrl import mst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.clr_ptr = 1'b1;
          state_d       = StFind;
        end
      end
      StFind: begin
        cmd_o.find = 1'b1;
        cmd_o.step = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.clr_ptr = 1'b1;
          cmd_o.clr_cnt = 1'b1;
          state_d       = StCount;
        end
      end
      StCount: begin
        cmd_o.count = 1'b1;
        cmd_o.step  = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.clr_ptr = 1'b1;
          state_d       = StDecide;
        end
      end
      StDecide: begin
        cmd_o.set_stat = 1'b1;
        cmd_o.stat     = StatDone;
        state_d        = StOut;
        if (stat_i.is_add) begin
          if (stat_i.occ_full || (!stat_i.found && stat_i.dist_full)) begin
            cmd_o.stat = StatFull;
          end else begin
            cmd_o.add = 1'b1;
            state_d   = StFcount;
          end
        end else if (stat_i.is_remove) begin
          if (!stat_i.found) begin
            cmd_o.stat = StatMissing;
          end else begin
            state_d = StLast;
          end
        end
      end
      StLast: begin
        cmd_o.last = 1'b1;
        if (stat_i.rd_hit) begin
          cmd_o.clr_ptr = 1'b1;
          state_d       = StShift;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        cmd_o.step  = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.clr_ptr = 1'b1;
          cmd_o.drop    = 1'b1;
          cmd_o.clr_cnt = 1'b1;
          state_d       = StRecount;
        end
      end
      StRecount: begin
        cmd_o.count = 1'b1;
        cmd_o.step  = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.clr_ptr = 1'b1;
          state_d       = stat_i.cnt_zero ? StDshift : StOut;
        end
      end
      StDshift: begin
        cmd_o.dshift = 1'b1;
        cmd_o.step   = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.clr_ptr = 1'b1;
          state_d       = StRenum;
        end
      end
      StRenum: begin
        cmd_o.renum = 1'b1;
        cmd_o.step  = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.ddrop = 1'b1;
          state_d     = StOut;
        end
      end
      StFcount: begin
        cmd_o.clr_ptr = 1'b1;
        cmd_o.clr_cnt = 1'b1;
        state_d       = StFinal;
      end
      StFinal: begin
        cmd_o.count = 1'b1;
        cmd_o.step  = 1'b1;
        if (stat_i.scan_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // A result waits until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  // No input is taken while a result is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("overlap of input and result");
  // An accepted word always starts with a search.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && in_valid_i |=> state_q == StFind) else $error("bad start");

endmodule

>>> sv/multiset_table.sv
// Top level of the multiset table with distinct value index.
// Each word takes several linear passes over the stores, driven by one scan
// pointer and one registered read per store: a search of the distinct store,
// a count over the occurrence store, for an add a recount after the append,
// and for a remove a backward search, a shift, a recount and, when a value
// leaves, a distinct shift and a renumber pass. One word is handled at a
// time. Stores need no clearing.
module multiset_table import mst_pkg::*; #(
  parameter int unsigned MaxItems    = MaxItemsDefault,
  parameter int unsigned MaxDistinct = MaxDistinctDefault,
  parameter int unsigned ValueBits   = ValueBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mst_in_if.sink      in_i,
  mst_out_if.source   out_o
);

  cmd_t  cmd;
  stat_t stat;

  mst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mst_datapath #(
    .MaxItems    (MaxItems),
    .MaxDistinct (MaxDistinct),
    .ValueBits   (ValueBits)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (in_i.kind),
    .value_i          (in_i.value),
    .stat_o           (stat),
    .status_o         (out_o.status),
    .occurrences_o    (out_o.occurrences),
    .total_items_o    (out_o.total_items),
    .distinct_items_o (out_o.distinct_items)
  );

endmodule
